// ===== src/atnr_pkg.sv =====
package atnr_pkg;

  localparam int LEVELS      = 16;
  localparam int MAX_ANCHORS = 32;
  localparam int DEPTH       = LEVELS * MAX_ANCHORS;
  localparam int AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LIW         = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_REMOVE = 3'd1;
  localparam logic [2:0] CMD_GET    = 3'd2;
  localparam logic [2:0] CMD_SELECT = 3'd3;
  localparam logic [2:0] CMD_ACTIVE = 3'd4;
  localparam logic [2:0] CMD_COUNT  = 3'd5;
  localparam logic [2:0] CMD_CLEAR  = 3'd6;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_LEVEL = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_BAD_INDEX = 3'd3;
  localparam logic [2:0] ST_NONE      = 3'd4;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [30:0]        radius;
    logic [30:0]        half_x;
    logic [30:0]        half_y;
    logic [30:0]        half_z;
  } anchor_t;

  typedef struct packed {
    logic       start;
    logic       valid;
    logic [5:0] idx;
  } dist_ctl_t;

  typedef struct packed {
    logic       busy;
    logic       have;
    logic [5:0] best_idx;
  } dist_sts_t;

  function automatic logic [AW-1:0] slot_addr(input logic [LIW-1:0] li, input logic [5:0] idx);
    slot_addr = AW'(AW'(li) * AW'(MAX_ANCHORS) + AW'(idx));
  endfunction

endpackage

// ===== src/atnr_if.sv =====
interface atnr_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic [4:0]         level;
  logic [5:0]         entry_index;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [30:0]        influence;
  logic [30:0]        half_x;
  logic [30:0]        half_y;
  logic [30:0]        half_z;

  modport source(output valid, cmd, level, entry_index, pos_x, pos_y, pos_z, influence,
                 half_x, half_y, half_z, input ready);
  modport sink(input valid, cmd, level, entry_index, pos_x, pos_y, pos_z, influence,
               half_x, half_y, half_z, output ready);
endinterface

interface atnr_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [5:0]         result_index;
  logic [5:0]         count_out;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic [30:0]        out_radius;
  logic [30:0]        out_half_x;
  logic [30:0]        out_half_y;
  logic [30:0]        out_half_z;
  logic               found;

  modport source(output valid, status, result_index, count_out, out_x, out_y, out_z,
                 out_radius, out_half_x, out_half_y, out_half_z, found, input ready);
  modport sink(input valid, status, result_index, count_out, out_x, out_y, out_z,
               out_radius, out_half_x, out_half_y, out_half_z, found, output ready);
endinterface

// ===== src/atnr_dist.sv =====
module atnr_dist (
  input  logic                clk,
  input  logic                rst,
  input  atnr_pkg::dist_ctl_t ctl,
  input  atnr_pkg::anchor_t   anchor,
  input  logic signed [31:0]  cam_x,
  input  logic signed [31:0]  cam_y,
  input  logic signed [31:0]  cam_z,
  output atnr_pkg::dist_sts_t sts
);

  logic signed [32:0] dx, dy, dz;
  logic [32:0] m1x, m1y, m1z;
  logic [30:0] r1;
  logic [5:0]  i1, i2, i3;
  logic        v1, v2, v3;
  logic [64:0] sq2x, sq2y, sq2z;
  logic [61:0] rr2, rr3;
  logic [66:0] sum3, best;
  logic        have;
  logic [5:0]  best_idx;

  function automatic logic [64:0] square(input logic [32:0] m);
    // magnitude of exactly 2^32 squares to 2^64
    square = m[32] ? {1'b1, 64'd0} : {1'b0, 64'(m[31:0]) * 64'(m[31:0])};
  endfunction

  always_comb begin
    dx = {anchor.x[31], anchor.x} - {cam_x[31], cam_x};
    dy = {anchor.y[31], anchor.y} - {cam_y[31], cam_y};
    dz = {anchor.z[31], anchor.z} - {cam_z[31], cam_z};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      have <= 1'b0;
    end else begin
      v1 <= ctl.valid;
      v2 <= v1;
      v3 <= v2;
      if (ctl.start) begin
        have <= 1'b0;
      end else if (v3 && (sum3 <= {5'd0, rr3}) && (!have || sum3 < best)) begin
        have <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    m1x  <= dx[32] ? 33'(-dx) : 33'(dx);
    m1y  <= dy[32] ? 33'(-dy) : 33'(dy);
    m1z  <= dz[32] ? 33'(-dz) : 33'(dz);
    r1   <= anchor.radius;
    i1   <= ctl.idx;
    sq2x <= square(m1x);
    sq2y <= square(m1y);
    sq2z <= square(m1z);
    rr2  <= r1 * r1;
    i2   <= i1;
    sum3 <= 67'(sq2x) + 67'(sq2y) + 67'(sq2z);
    rr3  <= rr2;
    i3   <= i2;
    // take only a strictly nearer anchor: first of equals stays
    if (v3 && (sum3 <= {5'd0, rr3}) && (!have || sum3 < best)) begin
      best     <= sum3;
      best_idx <= i3;
    end
  end

  assign sts.busy     = v1 | v2 | v3;
  assign sts.have     = have;
  assign sts.best_idx = best_idx;

endmodule

// ===== src/atnr_ctrl.sv =====
module atnr_ctrl (
  input  logic                clk,
  input  logic                rst,
  atnr_req_if.sink            req,
  atnr_rsp_if.source          rsp,
  output atnr_pkg::dist_ctl_t dctl,
  output atnr_pkg::anchor_t   rd_anchor,
  output logic signed [31:0]  cam_x,
  output logic signed [31:0]  cam_y,
  output logic signed [31:0]  cam_z,
  input  atnr_pkg::dist_sts_t dsts
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_SHIFT = 6'b000100,
    S_SCAN  = 6'b001000,
    S_DRAIN = 6'b010000,
    S_DONE  = 6'b100000
  } ctrl_state_t;

  ctrl_state_t state;

  atnr_pkg::anchor_t mem [atnr_pkg::DEPTH];
  atnr_pkg::anchor_t rdata, wr_data, req_anchor, res_anchor;
  logic [atnr_pkg::AW-1:0] rd_addr, wr_addr, wr_addr_q;
  logic wr_en, wr_pend, rd_vld;

  logic [5:0] counts [atnr_pkg::LEVELS];
  logic       active_valid;
  logic [atnr_pkg::LIW-1:0] active_level;
  logic [5:0] active_slot;

  logic [atnr_pkg::LIW-1:0] li_in, li_q;
  logic       lvl_ok, accept, idx_ok;
  logic [5:0] cnt_in, cnt_q, i, rd_idx;
  logic [2:0] res_status;
  logic [5:0] res_ridx, res_cnt;
  logic       res_found;

  assign lvl_ok = req.level < 5'(atnr_pkg::LEVELS);
  assign li_in  = lvl_ok ? req.level[atnr_pkg::LIW-1:0] : '0;
  assign cnt_in = lvl_ok ? counts[li_in] : 6'd0;
  assign idx_ok = lvl_ok && (req.entry_index < cnt_in);
  assign req.ready = (state == S_IDLE);
  assign accept = req.valid && req.ready;

  assign req_anchor = '{x: req.pos_x, y: req.pos_y, z: req.pos_z, radius: req.influence,
                        half_x: req.half_x, half_y: req.half_y, half_z: req.half_z};

  always_comb begin
    rd_addr = '0;
    case (state)
      S_IDLE: begin
        if (req.cmd == atnr_pkg::CMD_GET && idx_ok) begin
          rd_addr = atnr_pkg::slot_addr(li_in, req.entry_index);
        end else if (req.cmd == atnr_pkg::CMD_ACTIVE) begin
          rd_addr = atnr_pkg::slot_addr(active_level, active_slot);
        end
      end
      S_SCAN:  rd_addr = atnr_pkg::slot_addr(li_q, i);
      S_SHIFT: rd_addr = atnr_pkg::slot_addr(li_q, 6'(i + 6'd1));
      S_DRAIN: rd_addr = atnr_pkg::slot_addr(li_q, dsts.best_idx);
      default: rd_addr = '0;
    endcase
  end

  assign wr_en   = wr_pend || (accept && req.cmd == atnr_pkg::CMD_ADD && lvl_ok &&
                               cnt_in < 6'(atnr_pkg::MAX_ANCHORS));
  assign wr_addr = wr_pend ? wr_addr_q : atnr_pkg::slot_addr(li_in, cnt_in);
  assign wr_data = wr_pend ? rdata : req_anchor;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  assign dctl.start = accept && req.cmd == atnr_pkg::CMD_SELECT;
  assign dctl.valid = rd_vld;
  assign dctl.idx   = rd_idx;
  assign rd_anchor  = rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      for (int k = 0; k < atnr_pkg::LEVELS; k++) counts[k] <= 6'd0;
      active_valid <= 1'b0;
      active_level <= '0;
      active_slot  <= 6'd0;
      rd_vld       <= 1'b0;
      wr_pend      <= 1'b0;
      rsp.valid    <= 1'b0;
    end else begin
      rd_vld  <= 1'b0;
      wr_pend <= 1'b0;
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            li_q       <= li_in;
            cnt_q      <= cnt_in;
            i          <= req.entry_index;
            cam_x      <= req.pos_x;
            cam_y      <= req.pos_y;
            cam_z      <= req.pos_z;
            res_status <= atnr_pkg::ST_OK;
            res_ridx   <= 6'd0;
            res_cnt    <= cnt_in;
            res_found  <= 1'b0;
            res_anchor <= '0;
            state      <= S_DONE;
            case (req.cmd)
              atnr_pkg::CMD_ADD: begin
                if (!lvl_ok) begin
                  res_status <= atnr_pkg::ST_BAD_LEVEL;
                end else if (cnt_in >= 6'(atnr_pkg::MAX_ANCHORS)) begin
                  res_status <= atnr_pkg::ST_FULL;
                end else begin
                  res_ridx       <= cnt_in;
                  res_cnt        <= cnt_in + 6'd1;
                  counts[li_in]  <= cnt_in + 6'd1;
                end
              end
              atnr_pkg::CMD_REMOVE: begin
                if (!lvl_ok) begin
                  res_status <= atnr_pkg::ST_BAD_LEVEL;
                end else if (!idx_ok) begin
                  res_status <= atnr_pkg::ST_BAD_INDEX;
                end else begin
                  counts[li_in] <= cnt_in - 6'd1;
                  res_cnt       <= cnt_in - 6'd1;
                  active_valid  <= 1'b0;
                  if ({1'b0, req.entry_index} + 7'd1 < {1'b0, cnt_in}) begin
                    state <= S_SHIFT;
                  end
                end
              end
              atnr_pkg::CMD_GET: begin
                if (!lvl_ok) begin
                  res_status <= atnr_pkg::ST_BAD_LEVEL;
                end else if (!idx_ok) begin
                  res_status <= atnr_pkg::ST_BAD_INDEX;
                end else begin
                  res_ridx  <= req.entry_index;
                  res_found <= 1'b1;
                end
                state <= S_READ;
              end
              atnr_pkg::CMD_SELECT: begin
                active_valid <= 1'b0;
                if (!lvl_ok) begin
                  res_status <= atnr_pkg::ST_BAD_LEVEL;
                end else begin
                  i     <= 6'd0;
                  state <= (cnt_in == 6'd0) ? S_DRAIN : S_SCAN;
                end
              end
              atnr_pkg::CMD_ACTIVE: begin
                if (active_valid) begin
                  res_ridx  <= active_slot;
                  res_found <= 1'b1;
                  state     <= S_READ;
                end else begin
                  res_status <= atnr_pkg::ST_NONE;
                end
              end
              atnr_pkg::CMD_COUNT: begin
                if (!lvl_ok) begin
                  res_status <= atnr_pkg::ST_BAD_LEVEL;
                end
              end
              atnr_pkg::CMD_CLEAR: begin
                for (int k = 0; k < atnr_pkg::LEVELS; k++) counts[k] <= 6'd0;
                active_valid <= 1'b0;
                res_cnt      <= 6'd0;
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          res_anchor <= rdata;
          state      <= S_DONE;
        end
        S_SHIFT: begin
          // move entry i+1 down to i; write lands the next cycle
          wr_pend   <= 1'b1;
          wr_addr_q <= atnr_pkg::slot_addr(li_q, i);
          i         <= i + 6'd1;
          if ({1'b0, i} + 7'd2 >= {1'b0, cnt_q}) begin
            state <= S_DONE;
          end
        end
        S_SCAN: begin
          rd_vld <= 1'b1;
          rd_idx <= i;
          i      <= i + 6'd1;
          if ({1'b0, i} + 7'd1 >= {1'b0, cnt_q}) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_vld && !dsts.busy) begin
            if (dsts.have) begin
              active_valid <= 1'b1;
              active_level <= li_q;
              active_slot  <= dsts.best_idx;
              res_ridx     <= dsts.best_idx;
              res_found    <= 1'b1;
              state        <= S_READ;
            end else begin
              res_status <= atnr_pkg::ST_NONE;
              state      <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.status       <= res_status;
      rsp.result_index <= res_ridx;
      rsp.count_out    <= res_cnt;
      rsp.found        <= res_found;
      rsp.out_x        <= res_anchor.x;
      rsp.out_y        <= res_anchor.y;
      rsp.out_z        <= res_anchor.z;
      rsp.out_radius   <= res_anchor.radius;
      rsp.out_half_x   <= res_anchor.half_x;
      rsp.out_half_y   <= res_anchor.half_y;
      rsp.out_half_z   <= res_anchor.half_z;
    end
  end

endmodule

// ===== src/anchor_table_nearest_in_radius_top.sv =====
// Channel | Dir | Beat
// --------+-----+---------------------------------------------------------
// req     | in  | cmd, level, entry_index, pos_x/y/z, influence, half_x/y/z
// rsp     | out | status, result_index, count_out, out_* anchor data, found
//
// One command is in flight at a time; req is ready only when the sequencer is idle.
// Get and get active read one anchor from memory before the response is built.
// Remove moves each later entry down, one memory read/write per entry shifted.
// Select reads each anchor of the level, one per cycle, into a 4-stage distance pipe,
// then reads the winner.
// Reset clears level counts and the active anchor; the anchor memory is not cleared.
// The result register frees the sequencer: a stalled rsp holds one beat while the next
// command is taken.
module anchor_table_nearest_in_radius_top (
  input logic        clk,
  input logic        rst,
  atnr_req_if.sink   req,
  atnr_rsp_if.source rsp
);

  atnr_pkg::dist_ctl_t dctl;
  atnr_pkg::dist_sts_t dsts;
  atnr_pkg::anchor_t   rd_anchor;
  logic signed [31:0]  cam_x, cam_y, cam_z;

  // sequencer and anchor memory
  atnr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .dctl      (dctl),
    .rd_anchor (rd_anchor),
    .cam_x     (cam_x),
    .cam_y     (cam_y),
    .cam_z     (cam_z),
    .dsts      (dsts)
  );

  // squared distance pipe and nearest tracking
  atnr_dist u_dist (
    .clk    (clk),
    .rst    (rst),
    .ctl    (dctl),
    .anchor (rd_anchor),
    .cam_x  (cam_x),
    .cam_y  (cam_y),
    .cam_z  (cam_z),
    .sts    (dsts)
  );

`ifndef ASSERT_OFF
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.found |-> rsp.status == atnr_pkg::ST_OK)
    else $error("found beat with non-ok status");

  a_bad_level_count: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == atnr_pkg::ST_BAD_LEVEL |-> rsp.count_out == 6'd0)
    else $error("invalid level reports nonzero count");

  a_found_index: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.found |-> rsp.result_index < 6'(atnr_pkg::MAX_ANCHORS))
    else $error("found index out of table");

  a_pipe_idle_on_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |-> !dsts.busy)
    else $error("command taken while distance pipe busy");
`endif

endmodule
